>>> design/lec_pkg.sv
// Shared types and constants for the local extrema counter.
`timescale 1ns / 1ps

package lec_pkg;

    // Width of the result counts.
    localparam int TALLY_BITS = 19;
    localparam logic [TALLY_BITS-1:0] TALLY_TOP = '1;

    // Number of elements that can be judged in one cycle.
    localparam int JUDGE_COUNT = 4;

    // Configuration register indices.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd1;

    // Width of a count register.
    localparam int COUNT_BITS = 10;

    // Which neighbours of an element exist, and whether it is judged at all.
    typedef struct packed {
        logic active;
        logic has_up;
        logic has_down;
        logic has_left;
        logic has_right;
    } lec_nbrs_t;

    // Outcome of judging one element.
    typedef struct packed {
        logic is_max;
        logic is_min;
    } lec_verdict_t;

endpackage

>>> design/lec_line_mem.sv
// Line store: two previous rows per column, with read-after-write forwarding.
`timescale 1ns / 1ps

module lec_line_mem
    import lec_pkg::*;
#(
    parameter int DEPTH      = 512,
    parameter int DATA_BITS  = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_q_reg;
    logic [DATA_BITS-1:0] fwd_data_reg;
    logic                 fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        fwd_data_reg <= wr_data;
    end

    // A read and a write to the same entry in one cycle returns the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= rd_en && wr_en && (rd_addr == wr_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;

endmodule

>>> design/lec_judge.sv
// Compares one element with its existing four neighbours.
`timescale 1ns / 1ps

module lec_judge
    import lec_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  lec_nbrs_t                      nbrs,
    input  logic signed [SAMPLE_BITS-1:0]  centre,
    input  logic signed [SAMPLE_BITS-1:0]  up,
    input  logic signed [SAMPLE_BITS-1:0]  down,
    input  logic signed [SAMPLE_BITS-1:0]  left,
    input  logic signed [SAMPLE_BITS-1:0]  right,
    output lec_verdict_t                   verdict
);

    logic above;
    logic below;

    always_comb
    begin
        above = (!nbrs.has_up    || (centre > up))
             && (!nbrs.has_down  || (centre > down))
             && (!nbrs.has_left  || (centre > left))
             && (!nbrs.has_right || (centre > right));
        below = (!nbrs.has_up    || (centre < up))
             && (!nbrs.has_down  || (centre < down))
             && (!nbrs.has_left  || (centre < left))
             && (!nbrs.has_right || (centre < right));
        verdict.is_max = nbrs.active && above;
        verdict.is_min = nbrs.active && below;
    end

endmodule

>>> design/lec_tally.sv
// Running maxima and minima counts and the two-slot frame result queue.
`timescale 1ns / 1ps

module lec_tally
    import lec_pkg::*;
#(
    parameter int MAX_ROWS    = 512,
    parameter int MAX_COLUMNS = 512
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  logic                              frame_end,
    input  lec_verdict_t [JUDGE_COUNT-1:0]    verdicts,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic                              result_room,
    output logic [TALLY_BITS-1:0]             maxima_found,
    output logic [TALLY_BITS-1:0]             minima_found,
    output logic [TALLY_BITS-1:0]             extrema_found
);

    localparam int EXTREMA_TOP = MAX_ROWS * MAX_COLUMNS;
    localparam int INC_BITS    = $clog2(JUDGE_COUNT + 1);

    logic [TALLY_BITS-1:0] max_tally_reg;
    logic [TALLY_BITS-1:0] max_tally_next;
    logic [TALLY_BITS-1:0] min_tally_reg;
    logic [TALLY_BITS-1:0] min_tally_next;
    logic                  result_valid_reg;
    logic [TALLY_BITS-1:0] maxima_reg;
    logic [TALLY_BITS-1:0] minima_reg;
    logic [TALLY_BITS-1:0] extrema_reg;
    logic                  skid_valid_reg;
    logic [TALLY_BITS-1:0] skid_maxima_reg;
    logic [TALLY_BITS-1:0] skid_minima_reg;
    logic [TALLY_BITS-1:0] skid_extrema_reg;

    logic [INC_BITS-1:0]   max_inc;
    logic [INC_BITS-1:0]   min_inc;
    logic [TALLY_BITS:0]   max_sum;
    logic [TALLY_BITS:0]   min_sum;
    logic [TALLY_BITS-1:0] max_sat;
    logic [TALLY_BITS-1:0] min_sat;
    logic [TALLY_BITS:0]   ext_sum;
    logic [TALLY_BITS-1:0] ext_sat;

    logic                  result_take;
    logic                  head_free;
    logic [1:0]            held_after;

    always_comb
    begin
        max_inc = '0;
        min_inc = '0;
        for (int i = 0; i < JUDGE_COUNT; i++)
        begin
            max_inc = max_inc + INC_BITS'(verdicts[i].is_max);
            min_inc = min_inc + INC_BITS'(verdicts[i].is_min);
        end

        max_sum = {1'b0, max_tally_reg} + (TALLY_BITS+1)'(max_inc);
        min_sum = {1'b0, min_tally_reg} + (TALLY_BITS+1)'(min_inc);
        max_sat = (max_sum > {1'b0, TALLY_TOP}) ? TALLY_TOP : max_sum[TALLY_BITS-1:0];
        min_sat = (min_sum > {1'b0, TALLY_TOP}) ? TALLY_TOP : min_sum[TALLY_BITS-1:0];

        ext_sum = {1'b0, max_sat} + {1'b0, min_sat};
        if (32'(ext_sum) > 32'(EXTREMA_TOP))
        begin
            ext_sat = TALLY_BITS'(EXTREMA_TOP);
        end
        else
        begin
            ext_sat = ext_sum[TALLY_BITS-1:0];
        end

        if (restart || frame_end)
        begin
            max_tally_next = '0;
            min_tally_next = '0;
        end
        else
        begin
            max_tally_next = max_sat;
            min_tally_next = min_sat;
        end
    end

    // The skid slot is only ever filled while the output slot is held.
    assign result_take = result_valid_reg && !result_stall;
    assign head_free   = !result_valid_reg || result_take;
    assign held_after  = 2'(result_valid_reg) + 2'(skid_valid_reg) + 2'(frame_end)
                       - 2'(result_take);

    // Room for one more result after the edge that follows.
    assign result_room = (held_after <= 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tally_reg    <= '0;
            min_tally_reg    <= '0;
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            max_tally_reg <= max_tally_next;
            min_tally_reg <= min_tally_next;
            if (head_free)
            begin
                result_valid_reg <= skid_valid_reg || frame_end;
                skid_valid_reg   <= skid_valid_reg && frame_end;
            end
            else
            begin
                skid_valid_reg <= skid_valid_reg || frame_end;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                maxima_reg  <= skid_maxima_reg;
                minima_reg  <= skid_minima_reg;
                extrema_reg <= skid_extrema_reg;
            end
            else if (frame_end)
            begin
                maxima_reg  <= max_sat;
                minima_reg  <= min_sat;
                extrema_reg <= ext_sat;
            end
        end
        if (frame_end && (skid_valid_reg || !head_free))
        begin
            skid_maxima_reg  <= max_sat;
            skid_minima_reg  <= min_sat;
            skid_extrema_reg <= ext_sat;
        end
    end

    assign result_valid  = result_valid_reg;
    assign maxima_found  = maxima_reg;
    assign minima_found  = minima_reg;
    assign extrema_found = extrema_reg;

endmodule

>>> design/local_extrema_counter_top.sv
// Top level of the four-neighbour local extrema counter.
// Throughput: one sample per cycle while sample_stall is low, including the last row and frames of a single element.
// The frame result is registered into the result queue after the last sample passes stage 1.
// Two result slots let the last sample through while an earlier result still waits; it
// stalls only when a held result and one more would leave no room. Reset clears positions,
// counts and handshakes and sets both sizes to their defaults; the line memory is not cleared.
`timescale 1ns / 1ps

module local_extrema_counter_top
    import lec_pkg::*;
#(
    parameter int MAX_ROWS    = 512,
    parameter int MAX_COLUMNS = 512,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COUNT_BITS-1:0]         cfg_data,

    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [TALLY_BITS-1:0]         maxima_found,
    output logic [TALLY_BITS-1:0]         minima_found,
    output logic [TALLY_BITS-1:0]         extrema_found
);

    // Positions are held as indices; the size registers hold the last index in use.
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_RESET_LAST = ((MAX_ROWS < 512) ? MAX_ROWS : 512) - 1;
    localparam int COL_RESET_LAST = ((MAX_COLUMNS < 512) ? MAX_COLUMNS : 512) - 1;
    localparam int ENTRY_BITS = 2 * SAMPLE_BITS;

    // Raster position of the next sample to arrive, and the frame size.
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_last_reg;
    logic [ROW_W-1:0] row_last_next;
    logic [COL_W-1:0] col_last_reg;
    logic [COL_W-1:0] col_last_next;

    logic        cfg_write;
    logic        restart;
    logic [31:0] cfg_value32;
    logic [31:0] rows_clamped;
    logic [31:0] cols_clamped;

    logic sample_accept;
    logic at_row_end;
    logic at_col_end;
    logic result_room;

    // Stage 1: the accepted sample meets its column entry from the line memory.
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic                          s1_c_gt0_reg;
    logic                          s1_c_gt1_reg;
    logic                          s1_c_end_reg;
    logic                          s1_r_gt0_reg;
    logic                          s1_r_gt1_reg;
    logic                          s1_r_end_reg;

    // Comparison window of the previous two columns.
    logic signed [SAMPLE_BITS-1:0] prev_s_reg;
    logic signed [SAMPLE_BITS-1:0] prev_m_reg;
    logic signed [SAMPLE_BITS-1:0] prev_u_reg;
    logic signed [SAMPLE_BITS-1:0] prev2_m_reg;
    logic signed [SAMPLE_BITS-1:0] prev2_s_reg;

    logic [ENTRY_BITS-1:0]         rd_entry;
    logic signed [SAMPLE_BITS-1:0] cur_m;
    logic signed [SAMPLE_BITS-1:0] cur_u;

    lec_nbrs_t                     nbrs [JUDGE_COUNT];
    lec_verdict_t [JUDGE_COUNT-1:0] verdicts;
    logic                          frame_end;

    // The configuration port is always ready: the user must send writes only while the block is idle; not enforced.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write &&
                       ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COLUMN_COUNT));

    // A count of zero reads as one, and a count beyond the maximum reads as the maximum.
    always_comb
    begin
        cfg_value32 = 32'(cfg_data);
        if (cfg_value32 == 32'd0)
        begin
            rows_clamped = 32'd1;
            cols_clamped = 32'd1;
        end
        else
        begin
            rows_clamped = (cfg_value32 > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_value32;
            cols_clamped = (cfg_value32 > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : cfg_value32;
        end
    end

    assign at_row_end = (row_reg == row_last_reg);
    assign at_col_end = (col_reg == col_last_reg);

    // The last sample of a frame is held back unless the result queue is sure to
    // have a free slot when its result is written.
    assign sample_stall  = at_row_end && at_col_end && !result_room;
    assign sample_accept = sample_valid && !sample_stall;

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        row_last_next = row_last_reg;
        col_last_next = col_last_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
            if (cfg_index == REG_ROW_COUNT)
            begin
                row_last_next = ROW_W'(rows_clamped - 32'd1);
            end
            else
            begin
                col_last_next = COL_W'(cols_clamped - 32'd1);
            end
        end
        else if (sample_accept)
        begin
            if (at_col_end)
            begin
                col_next = '0;
                row_next = at_row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            row_last_reg <= ROW_W'(ROW_RESET_LAST);
            col_last_reg <= COL_W'(COL_RESET_LAST);
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_last_reg <= row_last_next;
            col_last_reg <= col_last_next;
            s1_valid_reg <= sample_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_sample_reg <= sample;
            s1_col_reg    <= col_reg;
            s1_c_gt0_reg  <= (col_reg != '0);
            s1_c_gt1_reg  <= (col_reg > COL_W'(1));
            s1_c_end_reg  <= at_col_end;
            s1_r_gt0_reg  <= (row_reg != '0);
            s1_r_gt1_reg  <= (row_reg > ROW_W'(1));
            s1_r_end_reg  <= at_row_end;
            s1_last_reg   <= at_row_end && at_col_end;
        end
        if (s1_valid_reg)
        begin
            prev_s_reg  <= s1_sample_reg;
            prev_m_reg  <= cur_m;
            prev_u_reg  <= cur_u;
            prev2_m_reg <= prev_m_reg;
            prev2_s_reg <= prev_s_reg;
        end
    end

    // Each column entry holds the sample of the row above and the one above that.
    lec_line_mem #(
        .DEPTH     (MAX_COLUMNS),
        .DATA_BITS (ENTRY_BITS)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (sample_accept),
        .rd_addr (col_reg),
        .rd_data (rd_entry),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_sample_reg, cur_m})
    );

    assign cur_m = rd_entry[ENTRY_BITS-1:SAMPLE_BITS];
    assign cur_u = rd_entry[SAMPLE_BITS-1:0];

    // Four judges cover every element by the time the frame ends.
    // The first judges the element of the row above, one column back, whose right
    // neighbour has just been read. The second judges the last element of the row
    // above, which has no right neighbour. On the last row of the frame the third
    // judges the element one column back in the current row, and the fourth judges
    // the final element of the frame.
    always_comb
    begin
        nbrs[0].active    = s1_valid_reg && s1_r_gt0_reg && s1_c_gt0_reg;
        nbrs[0].has_up    = s1_r_gt1_reg;
        nbrs[0].has_down  = 1'b1;
        nbrs[0].has_left  = s1_c_gt1_reg;
        nbrs[0].has_right = 1'b1;

        nbrs[1].active    = s1_valid_reg && s1_r_gt0_reg && s1_c_end_reg;
        nbrs[1].has_up    = s1_r_gt1_reg;
        nbrs[1].has_down  = 1'b1;
        nbrs[1].has_left  = s1_c_gt0_reg;
        nbrs[1].has_right = 1'b0;

        nbrs[2].active    = s1_valid_reg && s1_r_end_reg && s1_c_gt0_reg;
        nbrs[2].has_up    = s1_r_gt0_reg;
        nbrs[2].has_down  = 1'b0;
        nbrs[2].has_left  = s1_c_gt1_reg;
        nbrs[2].has_right = 1'b1;

        nbrs[3].active    = s1_valid_reg && s1_r_end_reg && s1_c_end_reg;
        nbrs[3].has_up    = s1_r_gt0_reg;
        nbrs[3].has_down  = 1'b0;
        nbrs[3].has_left  = s1_c_gt0_reg;
        nbrs[3].has_right = 1'b0;
    end

    lec_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_above_back (
        .nbrs    (nbrs[0]),
        .centre  (prev_m_reg),
        .up      (prev_u_reg),
        .down    (prev_s_reg),
        .left    (prev2_m_reg),
        .right   (cur_m),
        .verdict (verdicts[0])
    );

    lec_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_above_end (
        .nbrs    (nbrs[1]),
        .centre  (cur_m),
        .up      (cur_u),
        .down    (s1_sample_reg),
        .left    (prev_m_reg),
        .right   ('0),
        .verdict (verdicts[1])
    );

    lec_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_last_back (
        .nbrs    (nbrs[2]),
        .centre  (prev_s_reg),
        .up      (prev_m_reg),
        .down    ('0),
        .left    (prev2_s_reg),
        .right   (s1_sample_reg),
        .verdict (verdicts[2])
    );

    lec_judge #(.SAMPLE_BITS(SAMPLE_BITS)) u_judge_last_end (
        .nbrs    (nbrs[3]),
        .centre  (s1_sample_reg),
        .up      (cur_m),
        .down    ('0),
        .left    (prev_s_reg),
        .right   ('0),
        .verdict (verdicts[3])
    );

    assign frame_end = s1_valid_reg && s1_last_reg;

    lec_tally #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_tally (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .frame_end     (frame_end),
        .verdicts      (verdicts),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .result_room   (result_room),
        .maxima_found  (maxima_found),
        .minima_found  (minima_found),
        .extrema_found (extrema_found)
    );

endmodule
